// ===== rtl/tes_pkg.sv =====
package tes_pkg;

   localparam int DEF_TIMER_SLOTS = 16;
   localparam int DEF_MAX_FIRES   = 63;
   localparam int TIME_W          = 64;
   localparam int SLOT_W          = 4;
   localparam int MS_W            = 32;

   localparam logic [1:0] MODE_SET_TIME = 2'd0;
   localparam logic [1:0] MODE_START    = 2'd1;
   localparam logic [1:0] MODE_STOP     = 2'd2;
   localparam logic [1:0] MODE_TIMEOUT  = 2'd3;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [19:0]       NS_PER_MS = 20'd1000000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_APPLY,
      ST_SCAN,
      ST_DECIDE,
      ST_FIRE,
      ST_REPORT
   } state_type;

   // saturating 64-bit add
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

// ===== rtl/tes_min_scan.sv =====
module tes_min_scan #(
   parameter int TIMER_SLOTS = tes_pkg::DEF_TIMER_SLOTS,
   parameter int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        step_armed,
   input  logic [tes_pkg::TIME_W-1:0]  step_deadline,
   input  logic [IDX_W-1:0]            step_index,
   output logic                        best_valid,
   output logic [IDX_W-1:0]            best_index,
   output logic [tes_pkg::TIME_W-1:0]  best_deadline
);
   import tes_pkg::*;

   logic             best_valid_ff, best_valid_in;
   logic [IDX_W-1:0] best_index_ff, best_index_in;
   logic [TIME_W-1:0] best_deadline_ff, best_deadline_in;

   // one compare per cycle, strict less keeps the lower slot on ties
   always_comb begin
      best_valid_in    = start ? 1'b0 : best_valid_ff;
      best_index_in    = best_index_ff;
      best_deadline_in = best_deadline_ff;
      if (step_armed && (!best_valid_in || step_deadline < best_deadline_ff)) begin
         best_valid_in    = 1'b1;
         best_index_in    = step_index;
         best_deadline_in = step_deadline;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else begin
         best_valid_ff <= best_valid_in;
      end
      best_index_ff    <= best_index_in;
      best_deadline_ff <= best_deadline_in;
   end

   assign best_valid    = best_valid_ff;
   assign best_index    = best_index_ff;
   assign best_deadline = best_deadline_ff;

endmodule

// ===== rtl/timer_expiry_scheduler_core.sv =====
// Timer expiry scheduler. One request is taken at a time, and req_ready is low
// while it runs. Each request, after acceptance, passes through the multiply,
// apply, scan, decide and report steps, and a set-time request adds a fire,
// rescan and decide step for each firing. Fire and report cycles also wait
// while the result register still holds an earlier result that rsp_ready has
// not taken. One shared compare unit walks the slot table one entry per cycle
// to find the earliest armed deadline. Each request returns its firings
// (is_fire=1) in deadline order, then one closing report with rsp_last=1. The
// deadline and period tables are registers, written at one slot and read at
// the scan index each cycle.
module timer_expiry_scheduler_core #(
   parameter int TIMER_SLOTS = tes_pkg::DEF_TIMER_SLOTS,
   parameter int MAX_FIRES   = tes_pkg::DEF_MAX_FIRES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [tes_pkg::SLOT_W-1:0]      req_slot,
   input  logic [tes_pkg::TIME_W-1:0]      req_now_value,
   input  logic                            req_start_given,
   input  logic [tes_pkg::TIME_W-1:0]      req_start_time,
   input  logic                            req_interval_given,
   input  logic [tes_pkg::TIME_W-1:0]      req_interval_ns,
   input  logic signed [tes_pkg::MS_W-1:0] req_timeout_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_is_fire,
   output logic [tes_pkg::SLOT_W-1:0]      rsp_fired_slot,
   output logic                            rsp_notify,
   output logic                            rsp_next_valid,
   output logic [tes_pkg::TIME_W-1:0]      rsp_next_deadline,
   output logic                            rsp_overflow,
   output logic                            rsp_last
);
   import tes_pkg::*;

   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
   localparam int FC_W  = $clog2(MAX_FIRES + 1);

   // slot tables
   logic [TIMER_SLOTS-1:0] armed_ff;
   logic [TIME_W-1:0]      deadline_ff [TIMER_SLOTS];
   logic [TIME_W-1:0]      period_ff [TIMER_SLOTS];
   logic [TIME_W-1:0]      now_ff;
   logic [TIME_W-1:0]      earliest_ff;

   // request registers
   logic [1:0]        mode_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              sg_ff, ig_ff;
   logic [TIME_W-1:0] stime_ff, per_ff;
   logic [MS_W-1:0]   tms_ff;
   logic [TIME_W-1:0] prod_ff;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [FC_W-1:0]   fires_ff;
   logic              notify_ff, ovf_ff;

   logic              rsp_valid_ff, rsp_is_fire_ff, rsp_notify_ff;
   logic              rsp_next_valid_ff, rsp_overflow_ff, rsp_last_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [TIME_W-1:0] rsp_deadline_ff;

   logic              best_valid;
   logic [IDX_W-1:0]  best_index;
   logic [TIME_W-1:0] best_deadline;
   logic              scan_start, scan_step;
   logic [IDX_W-1:0]  scan_idx;
   logic              slot_ok;
   logic [IDX_W-1:0]  req_idx;
   logic              out_free;
   logic              rsp_load;
   logic              arm_req;

   assign scan_idx  = scan_ff[IDX_W-1:0];
   assign scan_step = (state_ff == ST_SCAN) && (scan_ff < CNT_W'(TIMER_SLOTS));
   assign slot_ok   = ({{(32-SLOT_W){1'b0}}, slot_ff} < 32'(TIMER_SLOTS));
   assign req_idx   = IDX_W'(slot_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = ((state_ff == ST_FIRE) || (state_ff == ST_REPORT)) && out_free;
   assign arm_req   = (mode_ff == MODE_START && (sg_ff || ig_ff))
                      || (mode_ff == MODE_TIMEOUT && !tms_ff[MS_W-1]);

   tes_min_scan #(
      .TIMER_SLOTS (TIMER_SLOTS),
      .IDX_W       (IDX_W)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (scan_start),
      .step_armed    (scan_step && armed_ff[scan_idx]),
      .step_deadline (deadline_ff[scan_idx]),
      .step_index    (scan_idx),
      .best_valid    (best_valid),
      .best_index    (best_index),
      .best_deadline (best_deadline)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL;
         ST_MUL:    state_in = ST_APPLY;
         ST_APPLY:  state_in = ST_SCAN;
         ST_SCAN:   if (!scan_step) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (mode_ff == MODE_SET_TIME && best_valid && best_deadline <= now_ff
                && fires_ff < FC_W'(MAX_FIRES)) state_in = ST_FIRE;
            else state_in = ST_REPORT;
         end
         ST_FIRE:   if (out_free) state_in = ST_SCAN;
         ST_REPORT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // scan control
   always_comb begin
      scan_start = (state_ff == ST_APPLY) || (state_ff == ST_FIRE && out_free);
      scan_in    = scan_start ? '0 : (scan_step ? scan_ff + 1'b1 : scan_ff);
   end

   assign req_ready = (state_ff == ST_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         armed_ff     <= '0;
         now_ff       <= '0;
         earliest_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         // result register: load a new result or drop the accepted one
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               mode_ff   <= req_mode;
               slot_ff   <= req_slot;
               sg_ff     <= req_start_given;
               ig_ff     <= req_start_given ? req_interval_given : req_interval_given;
               stime_ff  <= req_start_time;
               per_ff    <= req_interval_given ? req_interval_ns : '0;
               tms_ff    <= req_timeout_ms;
               fires_ff  <= '0;
               notify_ff <= 1'b0;
               ovf_ff    <= 1'b0;
               if (req_mode == MODE_SET_TIME) now_ff <= req_now_value;
            end
            ST_MUL: prod_ff <= {{(TIME_W-MS_W){1'b0}}, tms_ff} * {{(TIME_W-20){1'b0}}, NS_PER_MS};
            ST_APPLY: if (mode_ff != MODE_SET_TIME && slot_ok) begin
               // an arming request notifies; a stop of an armed slot notifies if something stays armed
               if (arm_req
                   || (armed_ff[req_idx] && (armed_ff & ~(TIMER_SLOTS'(1) << req_idx)) != '0))
                  notify_ff <= 1'b1;
               if (mode_ff == MODE_START && (sg_ff || ig_ff)) begin
                  armed_ff[req_idx]    <= 1'b1;
                  deadline_ff[req_idx] <= sg_ff ? stime_ff : sat_add(now_ff, per_ff);
                  period_ff[req_idx]   <= per_ff;
               end else if (mode_ff == MODE_TIMEOUT && !tms_ff[MS_W-1]) begin
                  armed_ff[req_idx]    <= 1'b1;
                  deadline_ff[req_idx] <= sat_add(now_ff, prod_ff);
                  period_ff[req_idx]   <= '0;
               end else begin
                  armed_ff[req_idx]    <= 1'b0;
               end
            end
            ST_DECIDE: begin
               if (mode_ff == MODE_SET_TIME && best_valid && best_deadline <= now_ff
                   && fires_ff >= FC_W'(MAX_FIRES)) ovf_ff <= 1'b1;
            end
            ST_FIRE: if (out_free) begin
               rsp_is_fire_ff    <= 1'b1;
               rsp_slot_ff       <= SLOT_W'(best_index);
               rsp_notify_ff     <= 1'b0;
               rsp_next_valid_ff <= 1'b0;
               rsp_deadline_ff   <= '0;
               rsp_overflow_ff   <= 1'b0;
               rsp_last_ff       <= 1'b0;
               fires_ff          <= fires_ff + 1'b1;
               if (period_ff[best_index] != '0)
                  deadline_ff[best_index] <= sat_add(best_deadline, period_ff[best_index]);
               else
                  armed_ff[best_index] <= 1'b0;
            end
            ST_REPORT: if (out_free) begin
               rsp_is_fire_ff    <= 1'b0;
               rsp_slot_ff       <= '0;
               rsp_notify_ff     <= notify_ff || (mode_ff == MODE_SET_TIME && best_valid);
               rsp_next_valid_ff <= best_valid;
               rsp_deadline_ff   <= best_valid ? best_deadline : '0;
               rsp_overflow_ff   <= ovf_ff;
               rsp_last_ff       <= 1'b1;
               if (best_valid) earliest_ff <= best_deadline;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_fire       = rsp_is_fire_ff;
   assign rsp_fired_slot    = rsp_slot_ff;
   assign rsp_notify        = rsp_notify_ff;
   assign rsp_next_valid    = rsp_next_valid_ff;
   assign rsp_next_deadline = rsp_deadline_ff;
   assign rsp_overflow      = rsp_overflow_ff;
   assign rsp_last          = rsp_last_ff;

   // checks
   a_fire_budget: assert property (@(posedge clock) disable iff (reset)
      fires_ff <= FC_W'(MAX_FIRES) || state_ff == ST_IDLE)
      else $error("fire count beyond limit");
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while busy");
   a_report_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT && out_free) |=> (rsp_valid && rsp_last && req_ready))
      else $error("report not issued");
   a_earliest_tracks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && rsp_next_valid && !$past(rsp_valid && !rsp_ready))
      |-> earliest_ff == rsp_next_deadline)
      else $error("earliest deadline mismatch");

endmodule
